// ===== rtl/fifo_free_list_allocator_defines.svh =====
// Assertion macros for the free list allocator.
`ifndef FIFO_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIFO_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("free list allocator check failed");

// Next-cycle implication, checked outside reset.
`define FAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("free list allocator check failed");

`endif

// ===== rtl/fal_pkg.sv =====
// Types and constants of the free list allocator.
package fal_pkg;

  localparam int unsigned LINK_W  = 7;
  localparam int unsigned GRANT_W = 6;
  localparam int unsigned INDEX_W = 8;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ===== rtl/fifo_free_list_allocator.sv =====
// Fixed pool free list allocator: link memory, head/tail pointers and stream ports.
//
// Input channel s_axis: tuser is the action (0 acquire, 1 release), tdata the
// entry index to release (ignored for an acquire). Output channel m_axis: one
// item per input item, tdata = {now_empty, granted_index[5:0], ok}.
// An item is accepted in ST_IDLE, during which the next link of the head is read
// from the synchronous link memory; ST_EXEC then uses that link once the output
// register is free, updates head, tail and the memory, and loads the output
// register. No new item is accepted until the update of the last one is done,
// and the result is then held in the output register.
// The output register holds a finished item while the receiver stalls; the
// next item is still accepted, and its update waits until the register frees.
// At reset the list holds every entry in order: a valid bit per entry, cleared
// at reset, makes an unwritten entry read as the link to the following entry,
// so no clearing pass is needed and items are accepted straight after reset.
// Release of an index at or beyond the pool size is ignored and answered with
// ok low. A double release is not detected.
`include "fifo_free_list_allocator_defines.svh"

module fifo_free_list_allocator #(
  parameter int unsigned POOL_ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] entry_index
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] ok, [6:1] granted_index, [7] now_empty
);

  localparam int unsigned IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam logic [fal_pkg::INDEX_W-1:0] POOL_LIM = fal_pkg::INDEX_W'(POOL_ENTRIES);

  fal_pkg::state_e state_q, state_d;

  logic [fal_pkg::LINK_W-1:0]  head_q, head_d;
  logic [fal_pkg::LINK_W-1:0]  tail_q, tail_d;
  logic                        empty_q, empty_d;
  logic                        action_q;
  logic [fal_pkg::INDEX_W-1:0] index_q;

  // link memory and its per-entry written marks
  logic [fal_pkg::LINK_W-1:0] mem_q [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0]    vld_q;
  logic [fal_pkg::LINK_W-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic [IDX_W-1:0]           rd_addr_q;

  logic                       s_accept;
  logic                       exec_go;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [fal_pkg::LINK_W-1:0] wr_data;
  logic [fal_pkg::INDEX_W-1:0] rst_next;
  logic [fal_pkg::LINK_W-1:0] link;

  logic                       m_valid_q;
  logic [7:0]                 m_data_q;
  logic                       res_ok;
  logic [fal_pkg::LINK_W-1:0] res_grant;

  assign s_axis_tready = (state_q == fal_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign exec_go       = (state_q == fal_pkg::ST_EXEC) && (!m_valid_q || m_axis_tready);

  // an unwritten entry reads as its reset link
  assign rst_next = fal_pkg::INDEX_W'(rd_addr_q) + 1'b1;
  assign link     = rd_vld_q ? rd_data_q
                  : ((rst_next == POOL_LIM) ? '0 : rst_next[fal_pkg::LINK_W-1:0]);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    wr_en     = 1'b0;
    wr_addr   = tail_q[IDX_W-1:0];
    wr_data   = index_q[fal_pkg::LINK_W-1:0];
    res_ok    = 1'b0;
    res_grant = '0;
    unique case (state_q)
      fal_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_d = fal_pkg::ST_EXEC;
        end
      end
      fal_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_d = fal_pkg::ST_IDLE;
          if (action_q == fal_pkg::ACT_ACQUIRE) begin
            if (!empty_q) begin
              res_ok    = 1'b1;
              res_grant = head_q;
              if (head_q == tail_q) begin
                empty_d = 1'b1;
              end else begin
                head_d = link;
              end
            end
          end else if (index_q < POOL_LIM) begin
            res_ok = 1'b1;
            tail_d = index_q[fal_pkg::LINK_W-1:0];
            if (empty_q) begin
              head_d  = index_q[fal_pkg::LINK_W-1:0];
              empty_d = 1'b0;
            end else begin
              wr_en = 1'b1;
            end
          end
        end
      end
      default: state_d = fal_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fal_pkg::ST_IDLE;
      head_q  <= '0;
      tail_q  <= fal_pkg::LINK_W'(POOL_ENTRIES - 1);
      empty_q <= 1'b0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // hold the item and the head link read while it waits for the update cycle
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      action_q  <= s_axis_tuser;
      index_q   <= s_axis_tdata;
      rd_addr_q <= head_q[IDX_W-1:0];
      rd_vld_q  <= vld_q[head_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (s_accept) begin
      rd_data_q <= mem_q[head_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (exec_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      m_data_q <= {empty_d, res_grant[fal_pkg::GRANT_W-1:0], res_ok};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `FAL_ASSERT_IMP(a_empty_head_tail, clk_i, rst_ni, empty_q, head_q == tail_q)
  `FAL_ASSERT_NXT(a_exec_gives_item, clk_i, rst_ni, exec_go, m_axis_tvalid)
  `FAL_ASSERT_IMP(a_no_write_on_read, clk_i, rst_ni, wr_en, !s_accept)

endmodule
